>>> hw/rtl/pdfrc4_pkg.sv
// Package for the PDF object RC4 cipher: MD5 round constants, shift table,
// register addresses and operation codes. No dependencies.
package pdfrc4_pkg;

  localparam int unsigned MinKey = 5;
  localparam int unsigned MaxKey = 16;

  localparam logic [4:0] AddrKeyLow  = 5'h00;
  localparam logic [4:0] AddrKeyHigh = 5'h08;
  localparam logic [4:0] AddrKeyLen  = 5'h10;

  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  function automatic logic [31:0] md5_k(input logic [5:0] n);
    logic [31:0] k;
    begin
      case (n)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] md5_s(input logic [3:0] idx);
    logic [4:0] s;
    begin
      case (idx)
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

endpackage

>>> hw/rtl/pdfrc4_md5.sv
// Single-block MD5 engine: one round step per cycle over a 16-word message.
// Depends on pdfrc4_pkg.
module pdfrc4_md5 (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [511:0] block,
  output logic         done,
  output logic [127:0] digest
);

  logic [511:0] msg;
  logic [31:0] a, b, c, d;
  logic [5:0] step;
  logic busy;
  logic [31:0] f, m_g, sum, rot;
  logic [3:0] g;
  logic [4:0] sh;

  always_comb begin
    unique case (step[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = step[3:0]; end
      2'd1: begin f = (d & b) | (~d & c); g = 4'(step * 6'd5 + 6'd1); end
      2'd2: begin f = b ^ c ^ d;          g = 4'(step * 6'd3 + 6'd5); end
      default: begin f = c ^ (b | ~d);    g = 4'(step * 6'd7); end
    endcase
    m_g = msg[32*g +: 32];
    sh  = pdfrc4_pkg::md5_s({step[5:4], step[1:0]});
    sum = a + f + pdfrc4_pkg::md5_k(step) + m_g;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        msg <= block;
        a <= 32'h67452301; b <= 32'hefcdab89; c <= 32'h98badcfe; d <= 32'h10325476;
      end else if (busy) begin
        a <= d; d <= c; c <= b; b <= b + rot;
        step <= step + 6'd1;
        if (step == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign digest = {d + 32'h10325476, c + 32'h98badcfe, b + 32'hefcdab89, a + 32'h67452301};

endmodule

>>> hw/rtl/pdf_object_rc4_decrypt.sv
// Per-object RC4 cipher top level: config port, key derivation and RC4 engine.
// Depends on pdfrc4_pkg and pdfrc4_md5.
//
// A start transfer runs MD5 (one round step per cycle), loads the 256-entry
// identity permutation and runs the key schedule (read S[i], read S[j], two
// swap writes per step); s_tready is low from accept until the key schedule
// ends. A data transfer reads S[i], reads S[j], makes two swap writes and
// reads the keystream on the single-port permutation memory, then loads the
// output register, so a new data transfer is accepted only once the last
// one has loaded its result; a result waiting in the output register holds
// the engine only when the next result is ready to load.
module pdf_object_rc4_decrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: object_number[23:0], generation[39:24], data_byte[47:40]
  input  logic [47:0] s_tdata,
  // tuser: operation
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: out_byte
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  localparam logic [3:0] StIdle = 4'd0, StMd5 = 4'd1, StFill = 4'd2, StKsA = 4'd3,
    StKsB = 4'd4, StKsC = 4'd5, StKsD = 4'd6, StDa = 4'd7, StDb = 4'd8,
    StDc = 4'd9, StDd = 4'd10, StDe = 4'd11, StOut = 4'd12;

  logic [63:0] file_key_low, file_key_high;
  logic [4:0] key_bytes;
  logic [3:0] state;
  logic [7:0] mem [256];
  logic [7:0] rd;
  logic [7:0] index_i, index_j, cnt, si, sj, data_r;
  logic [3:0] kidx;
  logic [4:0] klen;
  logic last_r;
  logic [127:0] okey;
  logic md5_start, md5_done;
  logic [127:0] digest;
  logic [511:0] blk;
  logic [4:0] kb;
  logic out_load, out_valid, out_last;
  logic [7:0] out_byte;

  // memory port
  logic we;
  logic [7:0] addr, wdata;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr)
      pdfrc4_pkg::AddrKeyLow:  prdata = file_key_low;
      pdfrc4_pkg::AddrKeyHigh: prdata = file_key_high;
      pdfrc4_pkg::AddrKeyLen:  prdata = {59'd0, key_bytes};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_key_low <= '0; file_key_high <= '0; key_bytes <= 5'(pdfrc4_pkg::MinKey);
    end else if (psel && penable && pwrite) begin
      if (paddr == pdfrc4_pkg::AddrKeyLow) file_key_low <= pwdata;
      if (paddr == pdfrc4_pkg::AddrKeyHigh) file_key_high <= pwdata;
      if (paddr == pdfrc4_pkg::AddrKeyLen) key_bytes <= pwdata[4:0];
    end
  end

  // message block build
  always_comb begin
    kb = key_bytes < 5'(pdfrc4_pkg::MinKey) ? 5'(pdfrc4_pkg::MinKey) :
         key_bytes > 5'(pdfrc4_pkg::MaxKey) ? 5'(pdfrc4_pkg::MaxKey) : key_bytes;
    blk = '0;
    for (int n = 0; n < 16; n++)
      if (5'(n) < kb) blk[8*n +: 8] = n < 8 ? file_key_low[8*(n%8) +: 8] :
                                               file_key_high[8*(n%8) +: 8];
    for (int n = 0; n < 5; n++)
      blk[8*(kb + 5'(n)) +: 8] = n < 3 ? s_tdata[8*n +: 8] : s_tdata[24 + 8*(n-3) +: 8];
    blk[8*(kb + 5'd5) +: 8] = 8'h80;
    blk[448 +: 16] = {8'd0, 3'd0, kb} * 16'd8 + 16'd40;
  end

  assign md5_start = s_tready && s_tvalid && s_tuser == pdfrc4_pkg::OpStart;
  pdfrc4_md5 u_md5 (.clk(clk), .rst(rst), .start(md5_start), .block(blk),
                    .done(md5_done), .digest(digest));

  assign s_tready = state == StIdle;
  assign out_load = state == StOut && (!out_valid || m_tready);

  always_comb begin
    we = 1'b0; addr = cnt; wdata = cnt;
    unique case (state) inside
      StFill: we = 1'b1;
      StKsB:  addr = sj + rd + okey[8*kidx +: 8];
      StKsC:  begin we = 1'b1; addr = cnt; wdata = rd; end
      StKsD:  begin we = 1'b1; addr = sj; wdata = si; end
      StDa:   addr = index_i;
      StDb:   addr = index_j + rd;
      StDc:   begin we = 1'b1; addr = index_i; wdata = rd; end
      StDd:   begin we = 1'b1; addr = index_j; wdata = si; end
      StDe, StOut: addr = si + sj;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle; index_i <= '0; index_j <= '0; okey <= '0;
    end else begin
      unique case (state)
        StIdle: if (s_tvalid) begin
          data_r <= s_tdata[47:40]; last_r <= s_tlast;
          if (s_tuser == pdfrc4_pkg::OpStart) begin
            klen <= kb + 5'd5 > 5'(pdfrc4_pkg::MaxKey) ? 5'(pdfrc4_pkg::MaxKey) :
                    kb + 5'd5;
            state <= StMd5;
          end else begin
            index_i <= index_i + 8'd1;
            state <= StDa;
          end
        end
        StMd5: if (md5_done) begin
          for (int n = 0; n < 16; n++)
            okey[8*n +: 8] <= 5'(n) < klen ? digest[8*n +: 8] : 8'd0;
          cnt <= '0; state <= StFill;
        end
        StFill: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'hFF) begin sj <= '0; kidx <= '0; state <= StKsA; end
        end
        StKsA: state <= StKsB;
        StKsB: begin
          si <= rd;
          sj <= sj + rd + okey[8*kidx +: 8];
          state <= StKsC;
        end
        StKsC: state <= StKsD;
        StKsD: begin
          cnt <= cnt + 8'd1;
          kidx <= {1'b0, kidx} + 5'd1 == klen ? 4'd0 : kidx + 4'd1;
          if (cnt == 8'hFF) begin
            index_i <= '0; index_j <= '0; state <= StIdle;
          end else begin
            state <= StKsA;
          end
        end
        StDa: state <= StDb;
        StDb: begin si <= rd; index_j <= index_j + rd; state <= StDc; end
        StDc: begin sj <= rd; state <= StDd; end
        StDd: state <= StDe;
        StDe: state <= StOut;
        StOut: if (out_load) state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1; out_byte <= data_r ^ rd; out_last <= last_r;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_byte;
  assign m_tlast = out_last;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for pdf_object_rc4_decrypt: APB key setup, stream
// stimulus with random gaps and stalls, and an MD5/RC4 predictor per transfer.
// Depends on pdfrc4_pkg and the block RTL.
module testbench;

  localparam int StartDrain = 1300;
  localparam int unsigned Limit = 3000000;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int RoundS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } cipher_out_t;

  typedef struct {
    bit          op;
    logic [23:0] obj;
    logic [15:0] gen;
    logic [7:0]  data;
    bit          last;
  } stim_row_t;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  logic        s_tvalid, s_tready, s_tuser, s_tlast;
  logic [47:0] s_tdata;
  logic        m_tvalid, m_tready, m_tlast;
  logic [7:0]  m_tdata;

  logic [63:0] key_lo_q, key_hi_q;
  logic [4:0]  key_len_q;
  logic [7:0]  sbox [256];
  logic [7:0]  idx_i, idx_j;
  cipher_out_t cipher_out_q [$];
  int unsigned cycles;
  int          errors;
  int          results_seen;

  pdf_object_rc4_decrypt DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void rc4_object_start(logic [23:0] obj, logic [15:0] gen);
    logic [7:0]  blk [64];
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, sum;
    logic [7:0]  dig [16];
    logic [7:0]  j, tmp;
    logic [31:0] hv [4];
    int          kb, klen, n, g, sh;
    kb = key_len_q < pdfrc4_pkg::MinKey ? pdfrc4_pkg::MinKey :
         (key_len_q > pdfrc4_pkg::MaxKey ? pdfrc4_pkg::MaxKey : key_len_q);
    for (n = 0; n < 64; n++) blk[n] = 8'h00;
    for (n = 0; n < kb; n++) blk[n] = n < 8 ? key_lo_q[8*n +: 8] : key_hi_q[8*(n-8) +: 8];
    blk[kb]   = obj[7:0];
    blk[kb+1] = obj[15:8];
    blk[kb+2] = obj[23:16];
    blk[kb+3] = gen[7:0];
    blk[kb+4] = gen[15:8];
    blk[kb+5] = 8'h80;
    blk[56]   = 8'((kb + 5) * 8);
    blk[57]   = 8'(((kb + 5) * 8) >> 8);
    for (n = 0; n < 16; n++) m[n] = {blk[4*n+3], blk[4*n+2], blk[4*n+1], blk[4*n]};
    hv = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
    for (n = 0; n < 64; n++) begin
      if (n < 16) begin
        f = (b & c) | (~b & d); g = n;
      end else if (n < 32) begin
        f = (d & b) | (~d & c); g = (5*n + 1) % 16;
      end else if (n < 48) begin
        f = b ^ c ^ d; g = (3*n + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7*n) % 16;
      end
      sh = RoundS[(n / 16) * 4 + n % 4];
      sum = a + f + RoundK[n] + m[g];
      t = d; d = c; c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = t;
    end
    hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
    for (n = 0; n < 16; n++) dig[n] = hv[n / 4][8*(n%4) +: 8];
    klen = kb + 5 > pdfrc4_pkg::MaxKey ? pdfrc4_pkg::MaxKey : kb + 5;
    for (n = 0; n < 256; n++) sbox[n] = 8'(n);
    j = 8'h00;
    for (n = 0; n < 256; n++) begin
      j = j + sbox[n] + dig[n % klen];
      tmp = sbox[n]; sbox[n] = sbox[j]; sbox[j] = tmp;
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
  endfunction

  function automatic cipher_out_t rc4_next_byte(logic [7:0] data, logic last);
    logic [7:0]  tmp;
    cipher_out_t r;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    tmp = sbox[idx_i]; sbox[idx_i] = sbox[idx_j]; sbox[idx_j] = tmp;
    r.out_byte = data ^ sbox[8'(sbox[idx_i] + sbox[idx_j])];
    r.last_out = last;
    return r;
  endfunction

  task automatic apb_write(logic [4:0] addr, logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == pdfrc4_pkg::AddrKeyLow) key_lo_q = value;
    else if (addr == pdfrc4_pkg::AddrKeyHigh) key_hi_q = value;
    else key_len_q = value[4:0];
  endtask

  task automatic send_item(bit op, logic [23:0] obj, logic [15:0] gen, logic [7:0] data,
                           bit last);
    int gap, roll;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {data, gen, obj};
    s_tlast  <= last;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (op == pdfrc4_pkg::OpStart) rc4_object_start(obj, gen);
    else cipher_out_q.push_back(rc4_next_byte(data, last));
    roll = $urandom_range(99);
    gap = roll < 60 ? 0 : (roll < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain(int extra);
    s_tvalid <= 1'b0;
    while (cipher_out_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // receiver: random stalls plus one long hold-off to back up the input
  initial begin
    int  stall_left;
    bit  held;
    int  roll;
    cipher_out_t want;
    stall_left = 0;
    held = 0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (cipher_out_q.size() == 0) begin
          $error("unexpected transfer out_byte=%h last_out=%b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = cipher_out_q.pop_front();
          if (m_tdata !== want.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last_out) begin
            $error("last_out expected %b actual %b", want.last_out, m_tlast);
            errors++;
          end
        end
      end
      if (!held && results_seen == 200) begin
        held = 1;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        roll = $urandom_range(99);
        if (roll < 20) stall_left = $urandom_range(1, 3);
        else if (roll < 22) stall_left = $urandom_range(20, 60);
      end
    end
  end

  initial begin
    stim_row_t   rows [$];
    logic [63:0] lo_set [6], hi_set [6];
    logic [4:0]  len_set [6];
    int          ph, sent, len, k, roll;
    logic [23:0] obj;
    logic [15:0] gen;
    rows = '{
      '{pdfrc4_pkg::OpStart, 24'h000000, 16'h0000, 8'h00, 1'b0},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'h00, 1'b0},
      '{pdfrc4_pkg::OpData,  24'hffffff, 16'hffff, 8'hff, 1'b0},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'h5a, 1'b1},
      '{pdfrc4_pkg::OpStart, 24'hffffff, 16'hffff, 8'hff, 1'b1},
      '{pdfrc4_pkg::OpData,  24'h123456, 16'h789a, 8'h00, 1'b1},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'hff, 1'b0},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'ha5, 1'b1},
      '{pdfrc4_pkg::OpStart, 24'h000001, 16'h0000, 8'h00, 1'b0},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'h01, 1'b0},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'h80, 1'b1},
      '{pdfrc4_pkg::OpStart, 24'h800000, 16'h8000, 8'h00, 1'b0},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'h7f, 1'b0},
      // restart mid-object
      '{pdfrc4_pkg::OpStart, 24'h00abcd, 16'h0001, 8'h00, 1'b0},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'hfe, 1'b0},
      '{pdfrc4_pkg::OpData,  24'h000000, 16'h0000, 8'h33, 1'b1}};
    lo_set  = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h0, 64'h0, 64'h0};
    hi_set  = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h0, 64'h0, 64'h0};
    // below-range and above-range lengths are clamped to 5 and 16
    len_set = '{5'd5, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17};
    for (k = 2; k < 6; k++) begin
      lo_set[k] = {$urandom, $urandom};
      hi_set[k] = {$urandom, $urandom};
    end
    key_lo_q = '0; key_hi_q = '0; key_len_q = 5'(pdfrc4_pkg::MinKey);
    idx_i = '0; idx_j = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tuser = 1'b0; s_tlast = 1'b0; s_tdata = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[r]) send_item(rows[r].op, rows[r].obj, rows[r].gen, rows[r].data,
                                rows[r].last);
    for (ph = 0; ph < 8; ph++) begin
      drain(StartDrain);
      k = ph < 6 ? ph : $urandom_range(2, 5);
      if (ph >= 6) len_set[k] = 5'($urandom_range(pdfrc4_pkg::MinKey, pdfrc4_pkg::MaxKey));
      apb_write(pdfrc4_pkg::AddrKeyLow, lo_set[k]);
      apb_write(pdfrc4_pkg::AddrKeyHigh, hi_set[k]);
      apb_write(pdfrc4_pkg::AddrKeyLen, {59'h0, len_set[k]});
      @(posedge clk);
      sent = 0;
      while (sent < 215) begin
        roll = $urandom_range(99);
        obj = roll < 10 ? 24'hffffff : (roll < 20 ? 24'h0 : 24'($urandom));
        gen = roll < 10 ? 16'hffff : (roll < 20 ? 16'h0 : 16'($urandom));
        send_item(pdfrc4_pkg::OpStart, obj, gen, 8'($urandom), 1'($urandom));
        len = $urandom_range(99) < 90 ? $urandom_range(1, 40) : $urandom_range(41, 200);
        for (k = 0; k < len; k++) begin
          roll = $urandom_range(99);
          send_item(pdfrc4_pkg::OpData, 24'($urandom), 16'($urandom), 8'($urandom),
                    roll < 5 ? 1'($urandom) : (k == len - 1 && roll < 95));
        end
        sent += len + 1;
      end
    end
    drain(50);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pdfrc4_pkg.sv
hw/rtl/pdfrc4_md5.sv
hw/rtl/pdf_object_rc4_decrypt.sv
dv/testbench.sv
